>>> sv/dsre_pkg.sv
// Shared constants for the dual stack rotate engine: operation codes,
// payload widths and parameter defaults. No dependencies.
package dsre_pkg;

    // Payload widths fixed by the channel definitions.
    localparam int OpW    = 4;
    localparam int ValueW = 32;
    localparam int CountW = 10;

    // Parameter defaults.
    localparam int DepthDefault      = 512;
    localparam int ValueWidthDefault = 32;

    // Operation codes.
    localparam logic [OpW-1:0] OP_CLEAR = 4'd0;
    localparam logic [OpW-1:0] OP_LOAD  = 4'd1;
    localparam logic [OpW-1:0] OP_SA    = 4'd2;
    localparam logic [OpW-1:0] OP_SB    = 4'd3;
    localparam logic [OpW-1:0] OP_SS    = 4'd4;
    localparam logic [OpW-1:0] OP_PA    = 4'd5;
    localparam logic [OpW-1:0] OP_PB    = 4'd6;
    localparam logic [OpW-1:0] OP_RA    = 4'd7;
    localparam logic [OpW-1:0] OP_RB    = 4'd8;
    localparam logic [OpW-1:0] OP_RR    = 4'd9;
    localparam logic [OpW-1:0] OP_RRA   = 4'd10;
    localparam logic [OpW-1:0] OP_RRB   = 4'd11;
    localparam logic [OpW-1:0] OP_RRR   = 4'd12;

endpackage

>>> sv/dsre_req_if.sv
// Request channel of the dual stack rotate engine: operation and load value.
// Depends on dsre_pkg for the payload widths.
interface dsre_req_if;
    logic                                valid;
    logic                                ready;
    logic [dsre_pkg::OpW-1:0]            op;
    logic signed [dsre_pkg::ValueW-1:0]  load_value;

    modport source (output valid, op, load_value, input ready);
    modport sink   (input valid, op, load_value, output ready);
endinterface

>>> sv/dsre_rsp_if.sv
// Response channel of the dual stack rotate engine: status, tops and counts.
// Depends on dsre_pkg for the payload widths.
interface dsre_rsp_if;
    logic                                valid;
    logic                                ready;
    logic                                status;
    logic signed [dsre_pkg::ValueW-1:0]  top_a;
    logic signed [dsre_pkg::ValueW-1:0]  top_b;
    logic [dsre_pkg::CountW-1:0]         count_a;
    logic [dsre_pkg::CountW-1:0]         count_b;

    modport source (output valid, status, top_a, top_b, count_a, count_b, input ready);
    modport sink   (input valid, status, top_a, top_b, count_a, count_b, output ready);
endinterface

>>> sv/dual_stack_rotate_engine.sv
// Dual stack rotate engine: two ring-buffer stacks in single-port memories.
// Each request is taken in the idle state, where the stack memories are read;
// the result is registered at the commit, where they are written. A new
// operation is taken only after the last one commits; a waiting result stalls the commit.
// Reset clears heads, lengths and control; stack memories are not cleared.
// Depends on dsre_pkg, dsre_req_if and dsre_rsp_if.
module dual_stack_rotate_engine #(
    parameter int DEPTH       = dsre_pkg::DepthDefault,
    parameter int VALUE_WIDTH = dsre_pkg::ValueWidthDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    dsre_req_if.sink    req,
    dsre_rsp_if.source  rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);
    localparam int VW = VALUE_WIDTH;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    typedef logic [AW-1:0]        addr_t;
    typedef logic [LW-1:0]        len_t;
    typedef logic signed [VW-1:0] val_t;

    // Position of entry off below the head, wrapped into the ring.
    function automatic addr_t ring_pos(input addr_t h, input len_t off);
        logic [LW:0] s;
        s = (LW+1)'(h) + (LW+1)'(off);
        if (s >= (LW+1)'(DEPTH))
            s = s - (LW+1)'(DEPTH);
        return AW'(s);
    endfunction

    function automatic addr_t ring_inc(input addr_t h);
        return (h == AW'(DEPTH - 1)) ? '0 : h + AW'(1);
    endfunction

    function automatic addr_t ring_dec(input addr_t h);
        return (h == '0) ? AW'(DEPTH - 1) : h - AW'(1);
    endfunction

    // The top of each stack lives in a register; the memory slot at the head
    // is stale and is written back when the top moves down into the stack.
    logic                     state_reg, state_next;
    logic [dsre_pkg::OpW-1:0] op_reg;
    val_t                     value_reg;
    logic                     fail_reg;
    addr_t                    head_a_reg, head_a_next, head_b_reg, head_b_next;
    len_t                     len_a_reg, len_a_next, len_b_reg, len_b_next;
    val_t                     top_a_reg, top_a_next, top_b_reg, top_b_next;

    logic                     rsp_valid_reg;
    logic                     status_reg;
    logic signed [dsre_pkg::ValueW-1:0] top_a_out_reg, top_b_out_reg;
    logic [dsre_pkg::CountW-1:0]        count_a_reg, count_b_reg;

    // Stack memories and their read data.
    val_t  mem_a [DEPTH];
    val_t  mem_b [DEPTH];
    val_t  rd_a_reg, rd_b_reg;
    logic  re_a, re_b, we_a, we_b;
    addr_t ra_a, ra_b, wa_a, wa_b;
    val_t  wd_a, wd_b;

    logic accept;
    logic commit;
    logic fail_now;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && (state_reg == S_IDLE);
    assign commit    = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp.ready);

    // Precondition check on the incoming operation.
    always_comb
    begin
        unique case (req.op) inside
            dsre_pkg::OP_CLEAR:
                fail_now = 1'b0;
            dsre_pkg::OP_LOAD:
                fail_now = ((LW+1)'(len_a_reg) + (LW+1)'(len_b_reg)) >= (LW+1)'(DEPTH);
            dsre_pkg::OP_SA:
                fail_now = (len_a_reg < LW'(2));
            dsre_pkg::OP_SB:
                fail_now = (len_b_reg < LW'(2));
            dsre_pkg::OP_SS:
                fail_now = (len_a_reg < LW'(2)) || (len_b_reg < LW'(2));
            dsre_pkg::OP_PB, dsre_pkg::OP_RA, dsre_pkg::OP_RRA:
                fail_now = (len_a_reg == '0);
            dsre_pkg::OP_PA, dsre_pkg::OP_RB, dsre_pkg::OP_RRB:
                fail_now = (len_b_reg == '0);
            dsre_pkg::OP_RR, dsre_pkg::OP_RRR:
                fail_now = (len_a_reg == '0) || (len_b_reg == '0);
            default:
                fail_now = 1'b1;
        endcase
    end

    // Read issue at transfer: the entry below the top, or the bottom for a
    // reverse rotate.
    always_comb
    begin
        re_a = 1'b0;
        re_b = 1'b0;
        unique case (req.op) inside
            dsre_pkg::OP_SA, dsre_pkg::OP_PB, dsre_pkg::OP_RA, dsre_pkg::OP_RRA:
                re_a = 1'b1;
            dsre_pkg::OP_SB, dsre_pkg::OP_PA, dsre_pkg::OP_RB, dsre_pkg::OP_RRB:
                re_b = 1'b1;
            dsre_pkg::OP_SS, dsre_pkg::OP_RR, dsre_pkg::OP_RRR:
            begin
                re_a = 1'b1;
                re_b = 1'b1;
            end
            default:
            begin
                re_a = 1'b0;
                re_b = 1'b0;
            end
        endcase
        re_a = re_a && accept && !fail_now;
        re_b = re_b && accept && !fail_now;
        if ((req.op == dsre_pkg::OP_RRA) || (req.op == dsre_pkg::OP_RRR))
            ra_a = ring_pos(head_a_reg, len_a_reg - LW'(1));
        else
            ra_a = ring_pos(head_a_reg, LW'(1));
        if ((req.op == dsre_pkg::OP_RRB) || (req.op == dsre_pkg::OP_RRR))
            ra_b = ring_pos(head_b_reg, len_b_reg - LW'(1));
        else
            ra_b = ring_pos(head_b_reg, LW'(1));
    end

    // Commit: write back and update heads, lengths and tops.
    always_comb
    begin
        head_a_next = head_a_reg;
        head_b_next = head_b_reg;
        len_a_next  = len_a_reg;
        len_b_next  = len_b_reg;
        top_a_next  = top_a_reg;
        top_b_next  = top_b_reg;
        we_a        = 1'b0;
        we_b        = 1'b0;
        wa_a        = head_a_reg;
        wa_b        = head_b_reg;
        wd_a        = top_a_reg;
        wd_b        = top_b_reg;
        if (commit && !fail_reg)
        begin
            unique case (op_reg) inside
                dsre_pkg::OP_CLEAR:
                begin
                    head_a_next = '0;
                    head_b_next = '0;
                    len_a_next  = '0;
                    len_b_next  = '0;
                end
                dsre_pkg::OP_LOAD:
                begin
                    we_a       = 1'b1;
                    wa_a       = ring_pos(head_a_reg, len_a_reg);
                    wd_a       = value_reg;
                    len_a_next = len_a_reg + LW'(1);
                    if (len_a_reg == '0)
                        top_a_next = value_reg;
                end
                dsre_pkg::OP_SA, dsre_pkg::OP_SB, dsre_pkg::OP_SS:
                begin
                    if (op_reg != dsre_pkg::OP_SB)
                    begin
                        we_a       = 1'b1;
                        wa_a       = ring_pos(head_a_reg, LW'(1));
                        top_a_next = rd_a_reg;
                    end
                    if (op_reg != dsre_pkg::OP_SA)
                    begin
                        we_b       = 1'b1;
                        wa_b       = ring_pos(head_b_reg, LW'(1));
                        top_b_next = rd_b_reg;
                    end
                end
                dsre_pkg::OP_PA:
                begin
                    we_a        = 1'b1;
                    head_a_next = ring_dec(head_a_reg);
                    len_a_next  = len_a_reg + LW'(1);
                    top_a_next  = top_b_reg;
                    head_b_next = ring_inc(head_b_reg);
                    len_b_next  = len_b_reg - LW'(1);
                    top_b_next  = rd_b_reg;
                end
                dsre_pkg::OP_PB:
                begin
                    we_b        = 1'b1;
                    head_b_next = ring_dec(head_b_reg);
                    len_b_next  = len_b_reg + LW'(1);
                    top_b_next  = top_a_reg;
                    head_a_next = ring_inc(head_a_reg);
                    len_a_next  = len_a_reg - LW'(1);
                    top_a_next  = rd_a_reg;
                end
                dsre_pkg::OP_RA, dsre_pkg::OP_RB, dsre_pkg::OP_RR:
                begin
                    if (op_reg != dsre_pkg::OP_RB)
                    begin
                        we_a        = 1'b1;
                        wa_a        = ring_pos(head_a_reg, len_a_reg);
                        head_a_next = ring_inc(head_a_reg);
                        if (len_a_reg != LW'(1))
                            top_a_next = rd_a_reg;
                    end
                    if (op_reg != dsre_pkg::OP_RA)
                    begin
                        we_b        = 1'b1;
                        wa_b        = ring_pos(head_b_reg, len_b_reg);
                        head_b_next = ring_inc(head_b_reg);
                        if (len_b_reg != LW'(1))
                            top_b_next = rd_b_reg;
                    end
                end
                dsre_pkg::OP_RRA, dsre_pkg::OP_RRB, dsre_pkg::OP_RRR:
                begin
                    // A single entry rotates onto itself: nothing moves.
                    if ((op_reg != dsre_pkg::OP_RRB) && (len_a_reg != LW'(1)))
                    begin
                        we_a        = 1'b1;
                        head_a_next = ring_dec(head_a_reg);
                        top_a_next  = rd_a_reg;
                    end
                    if ((op_reg != dsre_pkg::OP_RRA) && (len_b_reg != LW'(1)))
                    begin
                        we_b        = 1'b1;
                        head_b_next = ring_dec(head_b_reg);
                        top_b_next  = rd_b_reg;
                    end
                end
                default:
                begin
                    we_a = 1'b0;
                    we_b = 1'b0;
                end
            endcase
        end
    end

    // Sequencer: the idle state issues the read, the execute state commits.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (accept)
                    state_next = S_EXEC;
            S_EXEC:
                if (commit)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Stack A memory, one access per cycle.
    always_ff @(posedge clk)
    begin
        if (we_a)
            mem_a[wa_a] <= wd_a;
        if (re_a)
            rd_a_reg <= mem_a[ra_a];
    end

    // Stack B memory, one access per cycle.
    always_ff @(posedge clk)
    begin
        if (we_b)
            mem_b[wa_b] <= wd_b;
        if (re_b)
            rd_b_reg <= mem_b[ra_b];
    end

    // Operation capture at the request transfer.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= req.op;
            value_reg <= VW'(req.load_value);
            fail_reg  <= fail_now;
        end
    end

    // Cached tops and the registered result payload.
    always_ff @(posedge clk)
    begin
        top_a_reg <= top_a_next;
        top_b_reg <= top_b_next;
        if (commit)
        begin
            status_reg    <= fail_reg;
            top_a_out_reg <= (len_a_next == '0) ? '0 : dsre_pkg::ValueW'(top_a_next);
            top_b_out_reg <= (len_b_next == '0) ? '0 : dsre_pkg::ValueW'(top_b_next);
            count_a_reg   <= dsre_pkg::CountW'(len_a_next);
            count_b_reg   <= dsre_pkg::CountW'(len_b_next);
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_a_reg    <= '0;
            head_b_reg    <= '0;
            len_a_reg     <= '0;
            len_b_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_a_reg <= head_a_next;
            head_b_reg <= head_b_next;
            len_a_reg  <= len_a_next;
            len_b_reg  <= len_b_next;
            if (commit)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.status  = status_reg;
    assign rsp.top_a   = top_a_out_reg;
    assign rsp.top_b   = top_b_out_reg;
    assign rsp.count_a = count_a_reg;
    assign rsp.count_b = count_b_reg;

endmodule

>>> test/dual_stack_rotate_engine_tb.sv
// Testbench for the dual stack rotate engine: tracks both ring-buffer stacks
// and checks every response against it. Depends on dsre_pkg, dsre_req_if,
// dsre_rsp_if and dual_stack_rotate_engine.
module dual_stack_rotate_engine_tb;

    localparam int ClkHalf        = 5;
    localparam int ResetCycles    = 8;
    localparam int Depth          = dsre_pkg::DepthDefault;
    localparam int StallLimit     = 3000;
    localparam int DrainCycles    = 12;
    localparam int RandomPerPhase = 200;

    // Stack selectors.
    localparam int StkA = 0;
    localparam int StkB = 1;

    // Codes the block does not define.
    localparam logic [dsre_pkg::OpW-1:0] OP_UNUSED_LO = dsre_pkg::OP_RRR + 4'd1;
    localparam logic [dsre_pkg::OpW-1:0] OP_UNUSED_HI = 4'hF;

    localparam logic [dsre_pkg::ValueW-1:0] ValMin = {1'b1, {(dsre_pkg::ValueW-1){1'b0}}};
    localparam logic [dsre_pkg::ValueW-1:0] ValMax = {1'b0, {(dsre_pkg::ValueW-1){1'b1}}};

    typedef struct {
        logic                        status;
        logic [dsre_pkg::ValueW-1:0] top_a;
        logic [dsre_pkg::ValueW-1:0] top_b;
        logic [dsre_pkg::CountW-1:0] count_a;
        logic [dsre_pkg::CountW-1:0] count_b;
    } stacks_view_t;

    // Keeps its own copy of both stacks and the queue of expected views.
    class stack_pair_tracker;
        logic [dsre_pkg::ValueW-1:0] mem [2][Depth];
        int                          head [2];
        int                          len [2];
        stacks_view_t                expected_views [$];
        int                          mismatch_count;

        function new();
            head = '{0, 0};
            len = '{0, 0};
            mismatch_count = 0;
        endfunction

        function int slot(int s, int i);
            return (head[s] + i) % Depth;
        endfunction

        function void swap_top(int s);
            logic [dsre_pkg::ValueW-1:0] t;
            t = mem[s][slot(s, 0)];
            mem[s][slot(s, 0)] = mem[s][slot(s, 1)];
            mem[s][slot(s, 1)] = t;
        endfunction

        // The top entry moves to the slot just past the bottom.
        function void rotate_up(int s);
            mem[s][slot(s, len[s])] = mem[s][head[s]];
            head[s] = (head[s] + 1) % Depth;
        endfunction

        // The bottom entry moves to the slot just above the top.
        function void rotate_down(int s);
            logic [dsre_pkg::ValueW-1:0] v;
            v = mem[s][slot(s, len[s] - 1)];
            head[s] = (head[s] + Depth - 1) % Depth;
            mem[s][head[s]] = v;
        endfunction

        function void move_top(int dst, int src);
            logic [dsre_pkg::ValueW-1:0] v;
            v = mem[src][head[src]];
            head[src] = (head[src] + 1) % Depth;
            len[src]--;
            head[dst] = (head[dst] + Depth - 1) % Depth;
            mem[dst][head[dst]] = v;
            len[dst]++;
        endfunction

        function logic [dsre_pkg::ValueW-1:0] top_of(int s);
            return (len[s] == 0) ? '0 : mem[s][head[s]];
        endfunction

        // Applies one accepted request and queues the view it should produce.
        function void apply_op(logic [dsre_pkg::OpW-1:0] op,
                               logic [dsre_pkg::ValueW-1:0] value);
            bit           failed;
            stacks_view_t v;
            failed = 1'b0;
            case (op)
                dsre_pkg::OP_CLEAR:
                begin
                    head = '{0, 0};
                    len = '{0, 0};
                end
                dsre_pkg::OP_LOAD:
                    if (len[StkA] + len[StkB] >= Depth)
                        failed = 1'b1;
                    else
                    begin
                        mem[StkA][slot(StkA, len[StkA])] = value;
                        len[StkA]++;
                    end
                dsre_pkg::OP_SA:
                    if (len[StkA] < 2) failed = 1'b1;
                    else swap_top(StkA);
                dsre_pkg::OP_SB:
                    if (len[StkB] < 2) failed = 1'b1;
                    else swap_top(StkB);
                dsre_pkg::OP_SS:
                    if (len[StkA] < 2 || len[StkB] < 2)
                        failed = 1'b1;
                    else
                    begin
                        swap_top(StkA);
                        swap_top(StkB);
                    end
                dsre_pkg::OP_PA:
                    if (len[StkB] == 0) failed = 1'b1;
                    else move_top(StkA, StkB);
                dsre_pkg::OP_PB:
                    if (len[StkA] == 0) failed = 1'b1;
                    else move_top(StkB, StkA);
                dsre_pkg::OP_RA:
                    if (len[StkA] == 0) failed = 1'b1;
                    else rotate_up(StkA);
                dsre_pkg::OP_RB:
                    if (len[StkB] == 0) failed = 1'b1;
                    else rotate_up(StkB);
                dsre_pkg::OP_RR:
                    if (len[StkA] == 0 || len[StkB] == 0)
                        failed = 1'b1;
                    else
                    begin
                        rotate_up(StkA);
                        rotate_up(StkB);
                    end
                dsre_pkg::OP_RRA:
                    if (len[StkA] == 0) failed = 1'b1;
                    else rotate_down(StkA);
                dsre_pkg::OP_RRB:
                    if (len[StkB] == 0) failed = 1'b1;
                    else rotate_down(StkB);
                dsre_pkg::OP_RRR:
                    if (len[StkA] == 0 || len[StkB] == 0)
                        failed = 1'b1;
                    else
                    begin
                        rotate_down(StkA);
                        rotate_down(StkB);
                    end
                default:
                    failed = 1'b1;
            endcase
            v.status  = failed;
            v.top_a   = top_of(StkA);
            v.top_b   = top_of(StkB);
            v.count_a = dsre_pkg::CountW'(len[StkA]);
            v.count_b = dsre_pkg::CountW'(len[StkB]);
            expected_views.push_back(v);
        endfunction

        function void compare_field(string name, logic [dsre_pkg::ValueW-1:0] want,
                                    logic [dsre_pkg::ValueW-1:0] got);
            if (want !== got)
            begin
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
                mismatch_count++;
            end
        endfunction

        // Checks one response transfer against the oldest expected view.
        function void compare_result(stacks_view_t got);
            stacks_view_t want;
            if (expected_views.size() == 0)
            begin
                $display("%0t: unexpected response, expected none actual status %0d top_a %h",
                         $time, got.status, got.top_a);
                mismatch_count++;
                return;
            end
            want = expected_views.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("top_a", want.top_a, got.top_a);
            compare_field("top_b", want.top_b, got.top_b);
            compare_field("count_a", want.count_a, got.count_a);
            compare_field("count_b", want.count_b, got.count_b);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    dsre_req_if req_ch ();
    dsre_rsp_if rsp_ch ();

    dual_stack_rotate_engine u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    stack_pair_tracker tracker;
    int req_gap_pct   = 0;
    int rsp_stall_pct = 0;
    int quiet_cycles  = 0;
    int phase_gap [4]   = '{0, 79, 0, 29};
    int phase_stall [4] = '{0, 0, 79, 29};

    always #(ClkHalf) clk = ~clk;

    // Response side: ready changes at the falling edge.
    always @(negedge clk)
    begin
        rsp_ch.ready = rst_n && ($urandom_range(99) >= rsp_stall_pct);
    end

    // Response monitor: every transfer is checked at the rising edge.
    always @(posedge clk)
    begin : rsp_monitor
        stacks_view_t seen;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            seen.status  = rsp_ch.status;
            seen.top_a   = rsp_ch.top_a;
            seen.top_b   = rsp_ch.top_b;
            seen.count_a = rsp_ch.count_a;
            seen.count_b = rsp_ch.count_b;
            tracker.compare_result(seen);
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= StallLimit)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Presents one request until its transfer, then idles at random.
    task automatic send_op(input logic [dsre_pkg::OpW-1:0] op,
                           input logic [dsre_pkg::ValueW-1:0] value);
        req_ch.op = op;
        req_ch.load_value = value;
        req_ch.valid = 1'b1;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        tracker.apply_op(op, value);
        @(negedge clk);
        while ($urandom_range(99) < req_gap_pct)
        begin
            req_ch.valid = 1'b0;
            req_ch.op = dsre_pkg::OpW'($urandom);
            req_ch.load_value = $urandom;
            @(negedge clk);
        end
    endtask

    // Values lean toward the extremes now and then.
    function automatic logic [dsre_pkg::ValueW-1:0] pick_value();
        case ($urandom_range(15))
            0: return ValMin;
            1: return ValMax;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly loads and stack operations, with rare clears and unused codes.
    function automatic logic [dsre_pkg::OpW-1:0] pick_op();
        int r;
        r = $urandom_range(99);
        if (r < 2)
            return dsre_pkg::OP_CLEAR;
        if (r < 4)
            return dsre_pkg::OpW'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        if (r < 34)
            return dsre_pkg::OP_LOAD;
        return dsre_pkg::OpW'($urandom_range(dsre_pkg::OP_SA, dsre_pkg::OP_RRR));
    endfunction

    initial
    begin
        tracker = new();
        req_ch.valid = 1'b0;
        req_ch.op = dsre_pkg::OP_CLEAR;
        req_ch.load_value = '0;
        rst_n = 1'b0;
        repeat (ResetCycles) @(negedge clk);
        rst_n = 1'b1;

        // Swaps, pushes and single-stack rotates fail on empty stacks.
        send_op(dsre_pkg::OP_SA, '0);
        send_op(dsre_pkg::OP_SS, '0);
        send_op(dsre_pkg::OP_PA, '0);
        send_op(dsre_pkg::OP_PB, '0);
        send_op(dsre_pkg::OP_RA, '0);
        send_op(dsre_pkg::OP_RB, '0);
        send_op(dsre_pkg::OP_RRA, '0);
        send_op(dsre_pkg::OP_RRB, '0);

        // A single entry rotates in place; a dual rotate fails on empty B.
        send_op(dsre_pkg::OP_LOAD, ValMin);
        send_op(dsre_pkg::OP_RA, '0);
        send_op(dsre_pkg::OP_RRA, '0);
        send_op(dsre_pkg::OP_RR, '0);

        // Extreme values, then the other operations succeeding and the unused codes failing.
        send_op(dsre_pkg::OP_LOAD, ValMax);
        send_op(dsre_pkg::OP_LOAD, '0);
        send_op(dsre_pkg::OP_LOAD, '1);
        send_op(dsre_pkg::OP_SA, '0);
        send_op(dsre_pkg::OP_PB, '0);
        send_op(dsre_pkg::OP_PB, '0);
        send_op(dsre_pkg::OP_SB, '0);
        send_op(dsre_pkg::OP_SS, '0);
        send_op(dsre_pkg::OP_RR, '0);
        send_op(dsre_pkg::OP_RRR, '0);
        send_op(dsre_pkg::OP_RB, '0);
        send_op(dsre_pkg::OP_RRB, '0);
        send_op(dsre_pkg::OP_PA, '0);
        send_op(OP_UNUSED_LO, '0);
        send_op(OP_UNUSED_HI, '1);
        send_op(dsre_pkg::OP_CLEAR, '0);

        // Fill A to the full capacity, then loads must fail.
        while (tracker.len[StkA] + tracker.len[StkB] < Depth)
            send_op(dsre_pkg::OP_LOAD, pick_value());
        send_op(dsre_pkg::OP_LOAD, ValMax);
        send_op(dsre_pkg::OP_LOAD, ValMin);
        send_op(dsre_pkg::OP_RA, '0);
        send_op(dsre_pkg::OP_RRA, '0);
        send_op(dsre_pkg::OP_SA, '0);

        // Work on the full stacks, including wrap of both heads.
        repeat (48)
            send_op(dsre_pkg::OpW'($urandom_range(dsre_pkg::OP_LOAD, dsre_pkg::OP_RRR)),
                    pick_value());
        send_op(dsre_pkg::OP_CLEAR, '0);

        // Random traffic under each idling pattern.
        for (int ph = 0; ph < 4; ph++)
        begin
            req_gap_pct = phase_gap[ph];
            rsp_stall_pct = phase_stall[ph];
            repeat (RandomPerPhase)
                send_op(pick_op(), pick_value());
        end
        req_ch.valid = 1'b0;

        // Wait for every outstanding response, then a short drain.
        while (tracker.expected_views.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        if (tracker.mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
